// File: src/lsra_pkg.sv
// Package for the linear scan register allocator: sizes of the register
// file, positions, identifiers and result fields. No dependencies.
package lsra_pkg;

    localparam int MAX_REGS  = 8;
    localparam int POS_WIDTH = 16;
    localparam int ID_WIDTH  = 16;
    localparam int CFG_WIDTH = 4;
    localparam int ASG_WIDTH = 3;

    // Index of one register entry, and a width that holds the count itself.
    localparam int IDX_W = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam int CNT_W = $clog2(MAX_REGS + 1);
    localparam int CMP_W = (CNT_W > CFG_WIDTH) ? CNT_W : CFG_WIDTH;

    localparam logic [CFG_WIDTH-1:0] REG_COUNT_RESET = CFG_WIDTH'(8);

endpackage

// File: src/linear_scan_register_allocator.sv
// Linear scan register allocator: top level, uses lsra_pkg.
// Each interval walks every register entry in ST_SCAN and is then written back in ST_WRITE,
// after which out_valid rises; the writeback waits while a result is still pending.
// A new interval is taken only in ST_IDLE, once the writeback of the last one is done.
// Reset (rst_n, asynchronous, active low) clears all busy marks, sets reg_count to 8
// and empties the result register; the end and owner stores are not cleared.
module linear_scan_register_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write channel: reg_count only.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lsra_pkg::CFG_WIDTH-1:0]  cfg_data,
    // Interval input channel.
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [lsra_pkg::ID_WIDTH-1:0]   interval_id,
    input  logic [lsra_pkg::POS_WIDTH-1:0]  interval_start,
    input  logic [lsra_pkg::POS_WIDTH-1:0]  interval_end,
    // Result channel.
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lsra_pkg::ID_WIDTH-1:0]   result_id,
    output logic [lsra_pkg::ASG_WIDTH-1:0]  assigned_reg,
    output logic                            is_spilled,
    output logic                            evicted_valid,
    output logic [lsra_pkg::ID_WIDTH-1:0]   evicted_id
);
    import lsra_pkg::*;

    // The sequencer walks the register entries one per cycle. Each scan cycle
    // uses one comparator pair: the expiry test of the entry against the new
    // start, and the furthest-end test against the best candidate so far.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       scan_idx_reg, scan_idx_next;

    logic [CFG_WIDTH-1:0]   reg_count_reg;

    // Per register state. Busy marks reset; end and owner are only read while
    // the matching busy mark is set, so they need no reset.
    logic [MAX_REGS-1:0]    reg_busy_reg, reg_busy_next;
    logic [POS_WIDTH-1:0]   reg_end_reg   [MAX_REGS];
    logic [ID_WIDTH-1:0]    reg_owner_reg [MAX_REGS];

    // The interval being allocated.
    logic [ID_WIDTH-1:0]    cur_id_reg;
    logic [POS_WIDTH-1:0]   cur_start_reg;
    logic [POS_WIDTH-1:0]   cur_end_reg;

    // Scan results.
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   far_found_reg, far_found_next;
    logic [IDX_W-1:0]       far_idx_reg, far_idx_next;
    logic [POS_WIDTH-1:0]   far_end_reg, far_end_next;
    logic [ID_WIDTH-1:0]    far_owner_reg, far_owner_next;

    // Result register.
    logic                   out_valid_reg;
    logic [ID_WIDTH-1:0]    result_id_reg;
    logic [ASG_WIDTH-1:0]   assigned_reg_reg;
    logic                   is_spilled_reg;
    logic                   evicted_valid_reg;
    logic [ID_WIDTH-1:0]    evicted_id_reg;

    logic [CMP_W-1:0]       cfg_ext;
    logic [CMP_W-1:0]       active_cnt;
    logic                   in_range;
    logic [POS_WIDTH-1:0]   scan_end;
    logic [ID_WIDTH-1:0]    scan_owner;
    logic                   scan_expire;
    logic                   scan_busy;
    logic                   slot_free;
    logic                   do_write;
    logic                   do_evict;
    logic                   last_idx;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);

    assign out_valid     = out_valid_reg;
    assign result_id     = result_id_reg;
    assign assigned_reg  = assigned_reg_reg;
    assign is_spilled    = is_spilled_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_id    = evicted_id_reg;

    // A count above the number of physical registers saturates.
    assign cfg_ext    = CMP_W'(reg_count_reg);
    assign active_cnt = (cfg_ext > CMP_W'(MAX_REGS)) ? CMP_W'(MAX_REGS) : cfg_ext;

    // Per entry evaluation of the scan cycle.
    assign scan_end    = reg_end_reg[scan_idx_reg];
    assign scan_owner  = reg_owner_reg[scan_idx_reg];
    assign scan_expire = reg_busy_reg[scan_idx_reg] && (scan_end < cur_start_reg);
    assign scan_busy   = reg_busy_reg[scan_idx_reg] && !scan_expire;
    assign in_range    = (CMP_W'(scan_idx_reg) < active_cnt);
    assign last_idx    = (scan_idx_reg == IDX_W'(MAX_REGS - 1));

    // The writeback may only proceed when the result register is free or is
    // being drained in this same cycle.
    assign slot_free = !out_valid_reg || out_ready;
    assign do_write  = (state_reg == ST_WRITE) && slot_free;
    assign do_evict  = !free_found_reg && far_found_reg && (far_end_reg > cur_end_reg);

    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        reg_busy_next   = reg_busy_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        far_found_next  = far_found_reg;
        far_idx_next    = far_idx_reg;
        far_end_next    = far_end_reg;
        far_owner_next  = far_owner_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next      = ST_SCAN;
                    scan_idx_next   = '0;
                    free_found_next = 1'b0;
                    far_found_next  = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // Expiry applies to every entry, even those above the count.
                if (scan_expire)
                begin
                    reg_busy_next[scan_idx_reg] = 1'b0;
                end
                if (in_range)
                begin
                    if (!scan_busy)
                    begin
                        if (!free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = scan_idx_reg;
                        end
                    end
                    else if (!far_found_reg || (scan_end >= far_end_reg))
                    begin
                        // Greater or equal keeps the highest entry on a tie.
                        far_found_next = 1'b1;
                        far_idx_next   = scan_idx_reg;
                        far_end_next   = scan_end;
                        far_owner_next = scan_owner;
                    end
                end
                if (last_idx)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_WRITE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                    if (free_found_reg)
                    begin
                        reg_busy_next[free_idx_reg] = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_idx_reg   <= '0;
            reg_busy_reg   <= '0;
            reg_count_reg  <= REG_COUNT_RESET;
            free_found_reg <= 1'b0;
            far_found_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            reg_busy_reg   <= reg_busy_next;
            free_found_reg <= free_found_next;
            far_found_reg  <= far_found_next;
            if (cfg_valid && cfg_ready)
            begin
                reg_count_reg <= cfg_data;
            end
            if (do_write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        free_idx_reg  <= free_idx_next;
        far_idx_reg   <= far_idx_next;
        far_end_reg   <= far_end_next;
        far_owner_reg <= far_owner_next;

        if (in_valid && in_ready)
        begin
            cur_id_reg    <= interval_id;
            cur_start_reg <= interval_start;
            cur_end_reg   <= interval_end;
        end

        if (do_write)
        begin
            result_id_reg <= cur_id_reg;
            if (free_found_reg)
            begin
                reg_end_reg[free_idx_reg]   <= cur_end_reg;
                reg_owner_reg[free_idx_reg] <= cur_id_reg;
                assigned_reg_reg  <= ASG_WIDTH'(free_idx_reg);
                is_spilled_reg    <= 1'b0;
                evicted_valid_reg <= 1'b0;
                evicted_id_reg    <= '0;
            end
            else if (do_evict)
            begin
                // The furthest-ending owner gives up its register.
                reg_end_reg[far_idx_reg]   <= cur_end_reg;
                reg_owner_reg[far_idx_reg] <= cur_id_reg;
                assigned_reg_reg  <= ASG_WIDTH'(far_idx_reg);
                is_spilled_reg    <= 1'b0;
                evicted_valid_reg <= 1'b1;
                evicted_id_reg    <= far_owner_reg;
            end
            else
            begin
                assigned_reg_reg  <= '0;
                is_spilled_reg    <= 1'b1;
                evicted_valid_reg <= 1'b0;
                evicted_id_reg    <= '0;
            end
        end
    end

    // A transfer on the input always starts the scan at the first entry.
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_SCAN) && (scan_idx_reg == '0))
        else $error("scan did not start at entry zero after an input transfer");

    // A spilled interval never holds a register nor evicts another.
    a_spill_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_spilled) |-> (assigned_reg == '0) && !evicted_valid)
        else $error("spilled result carries a register or an eviction");

    // A register handed out from the free pool is marked busy afterwards.
    a_free_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (do_write && free_found_reg) |=> reg_busy_reg[$past(free_idx_reg)])
        else $error("allocated register not marked busy");

    // A register given to an interval lies below the active count.
    a_reg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (do_write && !is_spilled_reg && (free_found_reg || do_evict)) |=>
            (CMP_W'(assigned_reg_reg) < active_cnt))
        else $error("assigned register beyond the active count");

    // A new result never overwrites one that has not been transferred.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(result_id))
        else $error("pending result was overwritten");

endmodule
